// ===== rtl/rril_pkg.sv =====
// Shared types and codes for the round-robin list interleaver.
// Holds the transaction payload structs and the controller/datapath link.
// No dependencies.
`default_nettype none

package rril_pkg;

    // Operation codes carried in the op field
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_NEXT   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    // Width of the list_index field
    localparam int IDX_W = 3;

    // Input transaction payload
    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  list_index;
        logic signed [31:0] value;
    } rril_in_t;

    // Result transaction payload
    typedef struct packed {
        logic signed [31:0] out_value;
        logic [1:0]         status;
        logic               more_left;
    } rril_out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;  // capture the incoming transaction
        logic exec;       // perform append / clear / unused op and load result
        logic skip;       // advance the cursor past an empty position
        logic take;       // read the element under the cursor and advance
        logic none_left;  // answer a next with nothing left
        logic deliver;    // load the result from the element just read
    } rril_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       col_end;
        logic       row_hit;
        logic       out_free;
    } rril_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rril_ctrl.sv =====
// Controller state machine for the round-robin list interleaver.
// Sequences accept, cursor scan, element read and result load.
// Depends on rril_pkg.
`default_nettype none

module rril_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rril_pkg::rril_stat_t stat,
    output rril_pkg::rril_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       finish;

    // Next-state and command decode
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        finish     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                finish = 1'b1;
            end
            S_EXEC: begin
                if (stat.op == rril_pkg::OP_NEXT) begin
                    if (stat.count_zero || stat.col_end) begin
                        if (stat.out_free) begin
                            cmd.none_left = 1'b1;
                            finish        = 1'b1;
                        end
                    end else if (stat.row_hit) begin
                        cmd.take   = 1'b1;
                        state_next = S_READ;
                    end else begin
                        cmd.skip = 1'b1;
                    end
                end else if (stat.out_free) begin
                    cmd.exec = 1'b1;
                    finish   = 1'b1;
                end
            end
            S_READ: begin
                if (stat.out_free) begin
                    cmd.deliver = 1'b1;
                    finish      = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Take a new transaction as the current one completes
        s_ready = finish;
        if (finish) begin
            if (s_valid) begin
                cmd.load_item = 1'b1;
                state_next    = S_EXEC;
            end else begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rril_dpath.sv =====
// Datapath for the round-robin list interleaver: element memory, list
// lengths, zigzag cursor, remaining count and result register.
// Depends on rril_pkg.
`default_nettype none

module rril_dpath #(
    parameter int LISTS = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rril_pkg::rril_in_t   s_data,
    input  wire rril_pkg::rril_cmd_t  cmd,
    output rril_pkg::rril_stat_t      stat,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rril_pkg::rril_out_t       m_data
);

    localparam int ROW_W  = $clog2(LISTS);
    localparam int COL_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(LISTS * DEPTH + 1);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int IX_W   = ROW_W + rril_pkg::IDX_W;

    rril_pkg::rril_in_t  item_reg;
    rril_pkg::rril_out_t res_reg, res_next;
    logic                m_valid_reg, m_valid_next;

    logic [LEN_W-1:0] lens_reg  [LISTS];
    logic [LEN_W-1:0] lens_next [LISTS];
    logic [ROW_W-1:0] row_reg, row_next;
    logic [LEN_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [31:0] mem [2**ADDR_W];
    logic signed [31:0] mem_rd_reg;

    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  app_row;
    logic [LEN_W-1:0]  len_rd;
    logic              idx_ok;
    logic              full;
    logic              app_ok;
    logic              behind;
    logic              row_last;
    logic [ROW_W-1:0]  adv_row;
    logic [LEN_W-1:0]  adv_col;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [ADDR_W-1:0] mem_ra;

    // Length lookup: appends read their target list, nexts the cursor row
    always_comb begin
        app_row = ROW_W'(item_reg.list_index);
        rd_row  = (item_reg.op == rril_pkg::OP_APPEND) ? app_row : row_reg;
        len_rd  = (32'(rd_row) < LISTS) ? lens_reg[rd_row] : '0;
        idx_ok  = 32'(item_reg.list_index) < LISTS;
        full    = len_rd == LEN_W'(DEPTH);
        app_ok  = idx_ok && !full;
        // position (list_index, len_rd) already passed by the cursor
        behind  = (len_rd < col_reg) ||
                  ((len_rd == col_reg) &&
                   (IX_W'(item_reg.list_index) < IX_W'(row_reg)));
    end

    // Cursor step in zigzag order
    always_comb begin
        row_last = row_reg == ROW_W'(LISTS - 1);
        adv_row  = row_last ? '0 : row_reg + 1'b1;
        adv_col  = row_last ? col_reg + 1'b1 : col_reg;
    end

    // Status to the controller
    always_comb begin
        stat.op         = item_reg.op;
        stat.count_zero = cnt_reg == '0;
        stat.col_end    = col_reg == LEN_W'(DEPTH);
        stat.row_hit    = len_rd > col_reg;
        stat.out_free   = !m_valid_reg || m_ready;
    end

    // Memory port controls
    always_comb begin
        mem_we = cmd.exec && (item_reg.op == rril_pkg::OP_APPEND) && app_ok;
        mem_wa = {app_row, len_rd[COL_W-1:0]};
        mem_ra = {row_reg, col_reg[COL_W-1:0]};
    end

    // State and result updates
    always_comb begin
        lens_next    = lens_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (cmd.exec) begin
            res_next.out_value = '0;
            res_next.status    = rril_pkg::ST_OK;
            unique case (item_reg.op)
                rril_pkg::OP_APPEND: begin
                    if (app_ok) begin
                        lens_next[app_row] = len_rd + 1'b1;
                        if (!behind) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end else begin
                        res_next.status = rril_pkg::ST_DROPPED;
                    end
                end
                rril_pkg::OP_CLEAR: begin
                    lens_next = '{default: '0};
                    row_next  = '0;
                    col_next  = '0;
                    cnt_next  = '0;
                end
                default: begin
                end
            endcase
            m_valid_next = 1'b1;
        end

        if (cmd.skip) begin
            row_next = adv_row;
            col_next = adv_col;
        end

        if (cmd.take) begin
            row_next = adv_row;
            col_next = adv_col;
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.none_left) begin
            cnt_next           = '0;
            res_next.out_value = '0;
            res_next.status    = rril_pkg::ST_EMPTY;
            m_valid_next       = 1'b1;
        end

        if (cmd.deliver) begin
            res_next.out_value = mem_rd_reg;
            res_next.status    = rril_pkg::ST_OK;
            m_valid_next       = 1'b1;
        end

        if (cmd.exec || cmd.none_left || cmd.deliver) begin
            res_next.more_left = cnt_next != '0;
        end
    end

    // Element store: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= item_reg.value;
        end
        if (cmd.take) begin
            mem_rd_reg <= mem[mem_ra];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        res_reg <= res_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lens_reg    <= '{default: '0};
            row_reg     <= '0;
            col_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            lens_reg    <= lens_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

endmodule

`default_nettype wire

// ===== rtl/round_robin_list_interleaver.sv =====
// Round-robin list interleaver: LISTS lists of signed 32-bit values read
// back in zigzag order (column by column, list by list within a column).
// Input channel s_valid/s_ready/s_data carries one operation per
// transaction: append a value to a list, take the next value, or clear.
// Result channel m_valid/m_ready/m_data returns exactly one result per
// input transaction, in order: the value taken, a status (ok, append
// dropped, nothing left) and whether values remain.
// Timing: append, clear and the unused op load their result in the exec
// state and sustain one transaction per cycle while the result register is
// free. A next scans the cursor one row per cycle, skipping positions where
// the list at that row is too short; one that finds a value reads it through
// the registered element store port before delivery, one that finds nothing
// left answers from the scan. A new transaction is accepted as each result
// is loaded.
// Reset (aresetn low, synchronous) empties all lists, rewinds the cursor
// and drops any pending result; the element store itself is not cleared
// and needs no clearing pass.
// A stalled receiver holds the result register; one further transaction
// may be accepted and is held until the result register frees.
// Depends on rril_pkg, rril_ctrl and rril_dpath.
`default_nettype none

module round_robin_list_interleaver #(
    parameter int LISTS = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rril_pkg::rril_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rril_pkg::rril_out_t      m_data
);

    rril_pkg::rril_cmd_t  cmd;
    rril_pkg::rril_stat_t stat;

    rril_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rril_dpath #(
        .LISTS (LISTS),
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    // At most one datapath action per cycle
    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.exec, cmd.skip, cmd.take, cmd.none_left, cmd.deliver}))
        else $error("controller issued more than one datapath action");

    // A result is only loaded into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec || cmd.none_left || cmd.deliver) |-> stat.out_free)
        else $error("result loaded over an undelivered result");

    // The cursor scan only runs while stored values remain ahead of it
    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.skip || cmd.take) |-> !stat.count_zero)
        else $error("cursor moved with no values remaining");

    // A take is followed by its delivery before any new action
    a_take_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> !(cmd.exec || cmd.skip || cmd.take || cmd.none_left))
        else $error("action issued between element read and delivery");
`endif

endmodule

`default_nettype wire
